// File: sv/bftr_pkg.sv
// ----------------------------------------------------------------------------
// bftr_pkg
// Shared types, glyph ROM and mark table of the 5x7 text rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package bftr_pkg;

  localparam int GLYPH_COLUMNS   = 5;
  localparam int GLYPH_ROWS      = 7;
  localparam int DOT_COUNT       = GLYPH_COLUMNS * GLYPH_ROWS;
  localparam int GLYPH_SLOTS     = 36;
  localparam int COORD_BITS_DEF  = 16;
  localparam int ADVANCE_UNITS   = 6;
  localparam int APB_ADDR_BITS   = 3;
  localparam int MARK_ENTRIES    = 10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC_X,
    ST_CALC_Y,
    ST_CALC_W,
    ST_CALC_H,
    ST_EMIT,
    ST_ADVANCE
  } state_t;

  typedef enum logic {
    REG_PIXEL_SCALE = 1'b0,
    REG_DRAW_COLOR  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [3:0]  pixel_scale;
    logic [31:0] draw_color;
  } cfg_t;

  // mark rectangle in units of the scale
  typedef struct packed {
    logic [2:0] dx;
    logic [2:0] dy;
    logic [2:0] w;
    logic [2:0] h;
    logic       last;
  } mark_t;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_OPEN    = 8'h5B;
  localparam logic [7:0] CH_CLOSE   = 8'h5D;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] LETTER_BASE_SLOT = 8'd10;

  localparam logic [3:0] MARK_COLON  = 4'd0;
  localparam logic [3:0] MARK_PERIOD = 4'd2;
  localparam logic [3:0] MARK_DASH   = 4'd3;
  localparam logic [3:0] MARK_OPEN   = 4'd4;
  localparam logic [3:0] MARK_CLOSE  = 4'd7;

  localparam mark_t MARK_TABLE [MARK_ENTRIES] = '{
    '{3'd2, 3'd1, 3'd1, 3'd1, 1'b0},
    '{3'd2, 3'd3, 3'd1, 3'd1, 1'b1},
    '{3'd2, 3'd4, 3'd1, 3'd1, 1'b1},
    '{3'd1, 3'd3, 3'd3, 3'd1, 1'b1},
    '{3'd1, 3'd0, 3'd1, 3'd7, 1'b0},
    '{3'd2, 3'd0, 3'd1, 3'd1, 1'b0},
    '{3'd2, 3'd6, 3'd1, 3'd1, 1'b1},
    '{3'd3, 3'd0, 3'd1, 3'd7, 1'b0},
    '{3'd2, 3'd0, 3'd1, 3'd1, 1'b0},
    '{3'd2, 3'd6, 3'd1, 3'd1, 1'b1}
  };

  // columns 0..4 from the top byte down; bit r of a column is row r
  localparam logic [39:0] GLYPH_ROM [GLYPH_SLOTS] = '{
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h7C_12_11_12_7C, 40'h7F_49_49_49_36,
    40'h3E_41_41_41_22, 40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01,
    40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01,
    40'h7F_08_14_22_41, 40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F,
    40'h3E_41_41_41_3E, 40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46,
    40'h46_49_49_49_31, 40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F,
    40'h3F_40_38_40_3F, 40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43
  };

  // flattened dots, index col*GLYPH_ROWS + row, scan order
  function automatic logic [DOT_COUNT-1:0] glyph_dots(input logic [5:0] slot);
    logic [39:0]          entry;
    logic [DOT_COUNT-1:0] dots;
    entry = GLYPH_ROM[slot];
    dots  = '0;
    for (int c = 0; c < GLYPH_COLUMNS; c++) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        dots[c*GLYPH_ROWS + r] = entry[32 - 8*c + r];
      end
    end
    return dots;
  endfunction

endpackage

`default_nettype wire

// File: sv/bftr_if.sv
// ----------------------------------------------------------------------------
// bftr_if
// Valid/ready channels: character requests in, rectangle requests out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bftr_char_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_code;
  logic        start_text;
  logic [15:0] start_x;
  logic [15:0] start_y;

  modport source (output valid, char_code, start_text, start_x, start_y, input ready);
  modport sink   (input valid, char_code, start_text, start_x, start_y, output ready);
endinterface

interface bftr_rect_if;
  logic        valid;
  logic        ready;
  logic [15:0] rect_x;
  logic [15:0] rect_y;
  logic [6:0]  rect_w;
  logic [6:0]  rect_h;
  logic [31:0] rect_color;
  logic        last_rect;

  modport source (output valid, rect_x, rect_y, rect_w, rect_h, rect_color, last_rect,
                  input ready);
  modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, rect_color, last_rect,
                  output ready);
endinterface

`default_nettype wire

// File: sv/bftr_apb_regs.sv
// ----------------------------------------------------------------------------
// bftr_apb_regs
// APB register file: pixel_scale and draw_color.
// ----------------------------------------------------------------------------
`default_nettype none

module bftr_apb_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bftr_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                        pwdata,
  output      logic [31:0]                        prdata,
  output      logic                               pready,
  output      bftr_pkg::cfg_t                     cfg
);

  bftr_pkg::reg_index_t idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = bftr_pkg::reg_index_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_scale <= 4'd1;
      cfg.draw_color  <= 32'hFFFF_FFFF;
    end else if (wr_en) begin
      unique case (idx)
        bftr_pkg::REG_PIXEL_SCALE: cfg.pixel_scale <= pwdata[3:0];
        bftr_pkg::REG_DRAW_COLOR:  cfg.draw_color  <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bftr_pkg::REG_PIXEL_SCALE: prdata = {28'd0, cfg.pixel_scale};
      bftr_pkg::REG_DRAW_COLOR:  prdata = cfg.draw_color;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/bftr_scale_add.sv
// ----------------------------------------------------------------------------
// bftr_scale_add
// Shared unit: base + k * scale, saturated at the top of the coordinate range.
// ----------------------------------------------------------------------------
`default_nettype none

module bftr_scale_add #(
  parameter int COORD_BITS = bftr_pkg::COORD_BITS_DEF
) (
  input  wire logic [COORD_BITS-1:0] base,
  input  wire logic [2:0]            k,
  input  wire logic [3:0]            scale,
  output      logic [COORD_BITS-1:0] sum
);

  logic [6:0]          prod;
  logic [COORD_BITS:0] wide;

  assign prod = 7'(k) * 7'(scale);
  assign wide = {1'b0, base} + (COORD_BITS+1)'(prod);
  // carry out means past the top: clamp to all ones
  assign sum  = wide[COORD_BITS] ? '1 : wide[COORD_BITS-1:0];

endmodule

`default_nettype wire

// File: sv/bitmap_font_text_rasterizer_core.sv
// ----------------------------------------------------------------------------
// bitmap_font_text_rasterizer_core
// 5x7 bitmap character generator: one character request in, one rectangle
// request out per glyph dot or mark bar.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  char_in   in   valid/ready      char_code, start_text, start_x, start_y
//  rect_out  out  valid/ready      rect_x, rect_y, rect_w, rect_h, rect_color, last_rect
//  apb       in   psel/penable     paddr, pwdata, prdata (pready tied high)
//
// Steps: glyph = scan each dot up to the last set dot, a closing scan, X/Y/emit
// per set dot, cursor advance; mark = X/Y/W/H/emit per bar, advance; other = advance.
// All offsets, mark widths and heights and the advance go through one shared
// scale-add unit, one per cycle.
// Reset idles the sequencer, clears cursor and row, presets the registers; no clearing pass.
// A stalled rect_out holds the sequencer in its emit state; char_in is ready
// only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_font_text_rasterizer_core #(
  parameter int COORD_BITS = bftr_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  bftr_char_if.sink                               char_in,
  bftr_rect_if.source                             rect_out,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bftr_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                        pwdata,
  output      logic [31:0]                        prdata,
  output      logic                               pready
);

  localparam logic [15:0] COORD_MAX16 = 16'((32'd1 << COORD_BITS) - 32'd1);
  localparam int          DOTS        = bftr_pkg::DOT_COUNT;

  bftr_pkg::cfg_t   cfg;
  bftr_pkg::state_t state, state_next;

  logic [DOTS-1:0]       dots;
  logic [2:0]            col, row;
  logic [3:0]            mark_ptr;
  logic                  is_mark;
  logic [COORD_BITS-1:0] cursor_x, row_y;
  logic [COORD_BITS-1:0] rx, ry;
  logic [6:0]            rw, rh;

  logic [3:0]            scale;
  logic [COORD_BITS-1:0] unit_base, unit_sum;
  logic [2:0]            unit_k;
  bftr_pkg::mark_t       entry;

  logic                  in_take, out_take;
  logic                  in_glyph, in_mark;
  logic [7:0]            slot_wide;
  logic [3:0]            mark_start;
  logic [COORD_BITS-1:0] load_x, load_y;
  logic                  step;

  bftr_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bftr_scale_add #(.COORD_BITS(COORD_BITS)) u_unit (
    .base  (unit_base),
    .k     (unit_k),
    .scale (scale),
    .sum   (unit_sum)
  );

  assign scale    = (cfg.pixel_scale == 4'd0) ? 4'd1 : cfg.pixel_scale;
  assign entry    = bftr_pkg::MARK_TABLE[mark_ptr];
  assign in_take  = char_in.valid & char_in.ready;
  assign out_take = rect_out.valid & rect_out.ready;

  assign load_x = (char_in.start_x > COORD_MAX16) ? '1 : char_in.start_x[COORD_BITS-1:0];
  assign load_y = (char_in.start_y > COORD_MAX16) ? '1 : char_in.start_y[COORD_BITS-1:0];

  // character class of the incoming request
  always_comb begin
    in_glyph   = 1'b1;
    in_mark    = 1'b0;
    slot_wide  = 8'd0;
    mark_start = bftr_pkg::MARK_COLON;
    priority if (char_in.char_code >= bftr_pkg::CH_UPPER_A &&
                 char_in.char_code <= bftr_pkg::CH_UPPER_Z) begin
      slot_wide = char_in.char_code - bftr_pkg::CH_UPPER_A + bftr_pkg::LETTER_BASE_SLOT;
    end else if (char_in.char_code >= bftr_pkg::CH_LOWER_A &&
                 char_in.char_code <= bftr_pkg::CH_LOWER_Z) begin
      slot_wide = char_in.char_code - bftr_pkg::CH_LOWER_A + bftr_pkg::LETTER_BASE_SLOT;
    end else if (char_in.char_code >= bftr_pkg::CH_DIGIT_0 &&
                 char_in.char_code <= bftr_pkg::CH_DIGIT_9) begin
      slot_wide = char_in.char_code - bftr_pkg::CH_DIGIT_0;
    end else begin
      in_glyph = 1'b0;
      in_mark  = 1'b1;
      unique case (char_in.char_code)
        bftr_pkg::CH_COLON:  mark_start = bftr_pkg::MARK_COLON;
        bftr_pkg::CH_PERIOD: mark_start = bftr_pkg::MARK_PERIOD;
        bftr_pkg::CH_DASH:   mark_start = bftr_pkg::MARK_DASH;
        bftr_pkg::CH_OPEN:   mark_start = bftr_pkg::MARK_OPEN;
        bftr_pkg::CH_CLOSE:  mark_start = bftr_pkg::MARK_CLOSE;
        default:             in_mark    = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bftr_pkg::ST_IDLE: begin
        if (in_take) begin
          priority if (in_glyph) state_next = bftr_pkg::ST_SCAN;
          else if (in_mark)      state_next = bftr_pkg::ST_CALC_X;
          else                   state_next = bftr_pkg::ST_ADVANCE;
        end
      end
      bftr_pkg::ST_SCAN: begin
        priority if (dots == '0) state_next = bftr_pkg::ST_ADVANCE;
        else if (dots[0])        state_next = bftr_pkg::ST_CALC_X;
        else                     state_next = bftr_pkg::ST_SCAN;
      end
      bftr_pkg::ST_CALC_X: state_next = bftr_pkg::ST_CALC_Y;
      bftr_pkg::ST_CALC_Y: state_next = is_mark ? bftr_pkg::ST_CALC_W : bftr_pkg::ST_EMIT;
      bftr_pkg::ST_CALC_W: state_next = bftr_pkg::ST_CALC_H;
      bftr_pkg::ST_CALC_H: state_next = bftr_pkg::ST_EMIT;
      bftr_pkg::ST_EMIT: begin
        if (out_take) begin
          priority if (!is_mark) state_next = bftr_pkg::ST_SCAN;
          else if (entry.last)   state_next = bftr_pkg::ST_ADVANCE;
          else                   state_next = bftr_pkg::ST_CALC_X;
        end
      end
      bftr_pkg::ST_ADVANCE: state_next = bftr_pkg::ST_IDLE;
      default:              state_next = bftr_pkg::ST_IDLE;
    endcase
  end

  // outputs and shared unit operand select
  always_comb begin
    char_in.ready  = 1'b0;
    rect_out.valid = 1'b0;
    unit_base      = '0;
    unit_k         = 3'd0;
    unique case (state)
      bftr_pkg::ST_IDLE: char_in.ready = 1'b1;
      bftr_pkg::ST_CALC_X: begin
        unit_base = cursor_x;
        unit_k    = is_mark ? entry.dx : col;
      end
      bftr_pkg::ST_CALC_Y: begin
        unit_base = row_y;
        unit_k    = is_mark ? entry.dy : row;
      end
      bftr_pkg::ST_CALC_W: unit_k = entry.w;
      bftr_pkg::ST_CALC_H: unit_k = entry.h;
      bftr_pkg::ST_EMIT:   rect_out.valid = 1'b1;
      bftr_pkg::ST_ADVANCE: begin
        unit_base = cursor_x;
        unit_k    = 3'(bftr_pkg::ADVANCE_UNITS);
      end
      default: ;
    endcase
  end

  assign rect_out.rect_x     = 16'(rx);
  assign rect_out.rect_y     = 16'(ry);
  assign rect_out.rect_w     = rw;
  assign rect_out.rect_h     = rh;
  assign rect_out.rect_color = cfg.draw_color;
  // a glyph rectangle is last when no set dot remains behind it
  assign rect_out.last_rect  = is_mark ? entry.last : (dots[DOTS-1:1] == '0);

  // move on to the next dot: clear dot in scan, or a glyph dot just sent
  assign step = ((state == bftr_pkg::ST_SCAN) && (dots != '0) && !dots[0]) ||
                ((state == bftr_pkg::ST_EMIT) && out_take && !is_mark);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bftr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      row_y    <= '0;
    end else if (in_take && char_in.start_text) begin
      cursor_x <= load_x;
      row_y    <= load_y;
    end else if (state == bftr_pkg::ST_ADVANCE) begin
      cursor_x <= unit_sum;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      bftr_pkg::ST_IDLE: begin
        if (in_take) begin
          dots     <= bftr_pkg::glyph_dots(slot_wide[5:0]);
          is_mark  <= in_mark;
          mark_ptr <= mark_start;
          col      <= 3'd0;
          row      <= 3'd0;
        end
      end
      bftr_pkg::ST_CALC_X: rx <= unit_sum;
      bftr_pkg::ST_CALC_Y: begin
        ry <= unit_sum;
        rw <= 7'(scale);
        rh <= 7'(scale);
      end
      bftr_pkg::ST_CALC_W: rw <= unit_sum[6:0];
      bftr_pkg::ST_CALC_H: rh <= unit_sum[6:0];
      bftr_pkg::ST_EMIT: begin
        if (out_take && is_mark && !entry.last) mark_ptr <= mark_ptr + 4'd1;
      end
      default: ;
    endcase
    if (step) begin
      dots <= dots >> 1;
      if (row == 3'(bftr_pkg::GLYPH_ROWS - 1)) begin
        row <= 3'd0;
        col <= col + 3'd1;
      end else begin
        row <= row + 3'd1;
      end
    end
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    char_in.ready |-> !rect_out.valid)
    else $error("character taken while a rectangle is pending");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    rect_out.valid && rect_out.ready && rect_out.last_rect |=> !rect_out.valid)
    else $error("rectangle follows the last one of a character");

  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    rect_out.valid |-> (rect_out.rect_w != 7'd0) && (rect_out.rect_h != 7'd0))
    else $error("empty rectangle emitted");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    char_in.valid && char_in.ready |=> !char_in.ready)
    else $error("sequencer stayed idle after taking a character");

endmodule

`default_nettype wire

// File: tb/sv/glyph_rect_check_pkg.sv
// ----------------------------------------------------------------------------
// glyph_rect_check_pkg
// Rectangle prediction and in-order checking for the 5x7 text rasteriser
// testbench. It tracks the cursor, text row and both registers, expands each
// accepted character request into its rectangles, and compares each rectangle
// request from the block against the oldest one still due.
// ----------------------------------------------------------------------------
package glyph_rect_check_pkg;

  import bftr_pkg::*;

  localparam int          CELL_ADVANCE = 6;
  localparam int unsigned COORD_MAX    = (1 << COORD_BITS_DEF) - 1;

  typedef struct packed {
    logic [7:0]  code;
    logic        start;
    logic [15:0] sx;
    logic [15:0] sy;
  } char_req_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [6:0]  w;
    logic [6:0]  h;
    logic [31:0] color;
    logic        last;
  } rect_t;

  // digits then letters; one byte per column, bit r is row r (row 0 on top)
  localparam logic [7:0] FONT_COLS [36][5] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
  };

  class glyph_rect_tracker;
    logic [3:0]  scale_reg;
    logic [31:0] color_reg;
    logic [15:0] cursor;
    logic [15:0] text_row;
    rect_t       due_rects[$];
    int unsigned mismatches;

    function new();
      scale_reg  = 4'd1;
      color_reg  = 32'hFFFF_FFFF;
      cursor     = '0;
      text_row   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [31:0] value);
      if (idx == REG_PIXEL_SCALE) begin
        scale_reg = value[3:0];
      end else begin
        color_reg = value;
      end
    endfunction

    function logic [15:0] sat_coord(int unsigned base, int unsigned offset);
      int unsigned sum;
      sum = base + offset;
      return (sum > COORD_MAX) ? 16'(COORD_MAX) : 16'(sum);
    endfunction

    // offsets and sizes in dot units
    function void push_bar(int unsigned dx, int unsigned dy, int unsigned w, int unsigned h,
                           int unsigned s);
      rect_t r;
      r.x     = sat_coord(cursor, dx * s);
      r.y     = sat_coord(text_row, dy * s);
      r.w     = 7'(w * s);
      r.h     = 7'(h * s);
      r.color = color_reg;
      r.last  = 1'b0;
      due_rects.push_back(r);
    endfunction

    function void note_char(char_req_t req);
      int unsigned s;
      int          slot;
      int unsigned prior;
      logic [7:0]  col;
      s     = (scale_reg == 4'd0) ? 1 : scale_reg;
      slot  = -1;
      prior = due_rects.size();
      if (req.start) begin
        cursor   = req.sx;
        text_row = req.sy;
      end
      if (req.code >= CH_UPPER_A && req.code <= CH_UPPER_Z) begin
        slot = int'(LETTER_BASE_SLOT) + int'(req.code) - int'(CH_UPPER_A);
      end else if (req.code >= CH_LOWER_A && req.code <= CH_LOWER_Z) begin
        slot = int'(LETTER_BASE_SLOT) + int'(req.code) - int'(CH_LOWER_A);
      end else if (req.code >= CH_DIGIT_0 && req.code <= CH_DIGIT_9) begin
        slot = int'(req.code) - int'(CH_DIGIT_0);
      end
      if (slot >= 0) begin
        for (int c = 0; c < GLYPH_COLUMNS; c++) begin
          col = FONT_COLS[slot][c];
          for (int r = 0; r < GLYPH_ROWS; r++) begin
            if (col[r]) push_bar(c, r, 1, 1, s);
          end
        end
      end else begin
        case (req.code)
          CH_COLON: begin
            push_bar(2, 1, 1, 1, s);
            push_bar(2, 3, 1, 1, s);
          end
          CH_PERIOD: push_bar(2, 4, 1, 1, s);
          CH_DASH:   push_bar(1, 3, 3, 1, s);
          CH_OPEN: begin
            push_bar(1, 0, 1, 7, s);
            push_bar(2, 0, 1, 1, s);
            push_bar(2, 6, 1, 1, s);
          end
          CH_CLOSE: begin
            push_bar(3, 0, 1, 7, s);
            push_bar(2, 0, 1, 1, s);
            push_bar(2, 6, 1, 1, s);
          end
          default: ;
        endcase
      end
      if (due_rects.size() > prior) due_rects[due_rects.size() - 1].last = 1'b1;
      // unknown codes still move the cursor on
      cursor = sat_coord(cursor, CELL_ADVANCE * s);
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] seen,
                                longint unsigned stamp);
      if (want !== seen) begin
        mismatches++;
        $display("%0d ns: %s expected %0h got %0h", stamp, what, want, seen);
      end
    endfunction

    function void check_rect(rect_t seen, longint unsigned stamp);
      rect_t want;
      if (due_rects.size() == 0) begin
        mismatches++;
        $display("%0d ns: rectangle x=%0d y=%0d with none expected", stamp, seen.x, seen.y);
        return;
      end
      want = due_rects.pop_front();
      compare_field("rect_x", want.x, seen.x, stamp);
      compare_field("rect_y", want.y, seen.y, stamp);
      compare_field("rect_w", want.w, seen.w, stamp);
      compare_field("rect_h", want.h, seen.h, stamp);
      compare_field("rect_color", want.color, seen.color, stamp);
      compare_field("last_rect", want.last, seen.last, stamp);
    endfunction
  endclass

endpackage

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives character requests into the text rasteriser and checks every
// rectangle request against the predicted list, over directed corner cases
// and random text under several scale and colour settings, with random
// idling on both channels and one long stall on the rectangle side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bftr_pkg::*;
  import glyph_rect_check_pkg::*;

  localparam int unsigned STALL_LIMIT        = 2000;
  localparam int unsigned PRESSURE_HOLD      = 400;
  localparam int unsigned SETTLE_CYCLES      = 24;
  localparam int          RANDOM_PHASES      = 5;
  localparam int          RANDOM_PHASE_ITEMS = 52;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  bit steady_run;
  bit long_hold_pending;

  glyph_rect_tracker tracker = new();

  bftr_char_if char_ch ();
  bftr_rect_if rect_ch ();

  bitmap_font_text_rasterizer_core DUT (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_ch),
    .rect_out (rect_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_run) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // scale then colour, back to back on the APB port
  task automatic apply_settings(input logic [3:0] scale, input logic [31:0] color);
    reg_index_t  idx;
    logic [31:0] value;
    for (int i = 0; i < 2; i++) begin
      idx     = (i == 0) ? REG_PIXEL_SCALE : REG_DRAW_COLOR;
      value   = (i == 0) ? {28'd0, scale} : color;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      tracker.write_reg(idx, value);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_char(input logic [7:0] code, input logic start,
                           input logic [15:0] sx, input logic [15:0] sy);
    int unsigned gap;
    char_req_t   req;
    gap = pick_gap();
    if (gap != 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_ch.valid      <= 1'b1;
    char_ch.char_code  <= code;
    char_ch.start_text <= start;
    char_ch.start_x    <= sx;
    char_ch.start_y    <= sy;
    req = '{code: code, start: start, sx: sx, sy: sy};
    do @(posedge clk); while (!char_ch.ready);
    tracker.note_char(req);
  endtask

  // mostly drawable text, some raw bytes; origins often near the top of range
  task automatic send_random_char();
    logic [7:0]  code;
    logic        start;
    logic [15:0] sx;
    logic [15:0] sy;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      code = CH_UPPER_A + 8'($urandom_range(0, 25));
    end else if (pick < 50) begin
      code = CH_LOWER_A + 8'($urandom_range(0, 25));
    end else if (pick < 72) begin
      code = CH_DIGIT_0 + 8'($urandom_range(0, 9));
    end else if (pick < 87) begin
      case ($urandom_range(0, 4))
        0:       code = CH_COLON;
        1:       code = CH_PERIOD;
        2:       code = CH_DASH;
        3:       code = CH_OPEN;
        default: code = CH_CLOSE;
      endcase
    end else begin
      code = 8'($urandom_range(0, 255));
    end
    start = ($urandom_range(0, 7) == 0);
    sx    = 16'($urandom);
    sy    = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      sx = 16'hFFFF - 16'($urandom_range(0, 300));
      sy = 16'hFFFF - 16'($urandom_range(0, 120));
    end
    send_char(code, start, sx, sy);
  endtask

  task automatic settle();
    char_ch.valid <= 1'b0;
    while (tracker.due_rects.size() != 0) @(posedge clk);
    // a trailing code with no rectangles may still be in the sequencer
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : rect_sink
    int unsigned gap_left;
    int unsigned hold_left;
    rect_t       got;
    gap_left  = 0;
    hold_left = 0;
    rect_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rect_ch.valid && rect_ch.ready) begin
        got.x     = rect_ch.rect_x;
        got.y     = rect_ch.rect_y;
        got.w     = rect_ch.rect_w;
        got.h     = rect_ch.rect_h;
        got.color = rect_ch.rect_color;
        got.last  = rect_ch.last_rect;
        tracker.check_rect(got, $time);
        gap_left = pick_gap();
      end
      if (long_hold_pending) begin
        hold_left         = PRESSURE_HOLD;
        long_hold_pending = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rect_ch.ready <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        rect_ch.ready <= 1'b0;
      end else begin
        rect_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || psel || (char_ch.valid && char_ch.ready) ||
          (rect_ch.valid && rect_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("bitmap_font_text_rasterizer_core verification failed");
    $finish;
  end

  initial begin : stimulus
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    char_ch.valid      <= 1'b0;
    char_ch.char_code  <= '0;
    char_ch.start_text <= 1'b0;
    char_ch.start_x    <= '0;
    char_ch.start_y    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: every glyph class, every mark, unknown codes
    send_char(CH_UPPER_A, 1'b1, 16'd0, 16'd0);
    send_char(CH_LOWER_Z, 1'b0, 16'hFFFF, 16'hFFFF);
    send_char(CH_DIGIT_0, 1'b0, 16'd0, 16'd0);
    send_char(CH_DIGIT_9, 1'b0, 16'd0, 16'd0);
    send_char(CH_COLON, 1'b0, 16'd0, 16'd0);
    send_char(CH_PERIOD, 1'b0, 16'd0, 16'd0);
    send_char(CH_DASH, 1'b0, 16'd0, 16'd0);
    send_char(CH_OPEN, 1'b0, 16'd0, 16'd0);
    send_char(CH_CLOSE, 1'b0, 16'd0, 16'd0);
    send_char(" ", 1'b0, 16'd0, 16'd0);
    send_char(8'h00, 1'b0, 16'd0, 16'd0);
    send_char(8'hFF, 1'b0, 16'd0, 16'd0);
    send_char(8'h80, 1'b1, 16'd300, 16'd40);
    send_char("M", 1'b1, 16'hFFFF, 16'hFFFF);
    settle();

    // largest dots near the corner of the coordinate range
    apply_settings(4'd15, 32'h0000_0000);
    send_char("W", 1'b1, 16'd65500, 16'd65400);
    send_char("8", 1'b0, 16'd0, 16'd0);
    send_char(CH_CLOSE, 1'b0, 16'd0, 16'd0);
    send_char(CH_DASH, 1'b1, 16'd65530, 16'd0);
    send_char(CH_OPEN, 1'b1, 16'd0, 16'd0);
    send_char("#", 1'b0, 16'd0, 16'd0);
    settle();

    // zero scale draws as one
    apply_settings(4'd0, 32'hA5A5_5A5A);
    send_char("O", 1'b1, 16'd100, 16'd200);
    send_char(CH_COLON, 1'b0, 16'd0, 16'd0);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_settings(4'd1, $urandom);
        1: begin
          apply_settings(4'd15, 32'hFFFF_FFFF);
          long_hold_pending = 1'b1;
        end
        2: begin
          steady_run = 1'b1;
          apply_settings(4'($urandom_range(2, 14)), $urandom);
        end
        3: begin
          steady_run = 1'b0;
          apply_settings(4'd0, $urandom);
        end
        default: apply_settings(4'($urandom_range(1, 15)), 32'h0000_0000);
      endcase
      repeat (RANDOM_PHASE_ITEMS) send_random_char();
      settle();
    end

    if (tracker.mismatches == 0) begin
      $display("bitmap_font_text_rasterizer_core verification clean");
    end else begin
      $display("bitmap_font_text_rasterizer_core verification failed");
    end
    $finish;
  end

endmodule
